// File: sv/ctf_pkg.sv
// Shared types, constants and register map of the complementary tilt filter.
`default_nettype none

package ctf_pkg;

   // Field widths of the transaction payloads
   localparam int INDEX_W = 3;
   localparam int ROLL_W  = 25;
   localparam int PITCH_W = 24;
   localparam int GYRO_W  = 16;
   localparam int GAIN_W  = 16;
   localparam int WEIGHT_W = 17;
   localparam int FRAC_W  = 16;

   // Angle limits in 16.16 degrees
   localparam int ROLL_LIMIT  = 11796480;
   localparam int PITCH_LIMIT = 5898240;

   // Default number of tracked sensors
   localparam int SENSOR_COUNT_DEF = 5;

   // Digit-serial multiplier: multiplier bits consumed per cycle
   localparam int DIGIT_W       = 8;
   localparam int GAIN_DIGITS   = (GAIN_W + DIGIT_W - 1) / DIGIT_W;
   localparam int WEIGHT_DIGITS = (WEIGHT_W + DIGIT_W - 1) / DIGIT_W;
   localparam int CNT_W         = $clog2(WEIGHT_DIGITS);

   // Register file
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_SEL_W  = CSR_ADDR_W - 2;
   localparam logic [REG_SEL_W-1:0] REG_GYRO_WEIGHT    = 2'd0;
   localparam logic [REG_SEL_W-1:0] REG_ACCEL_WEIGHT   = 2'd1;
   localparam logic [REG_SEL_W-1:0] REG_GYRO_STEP_GAIN = 2'd2;

   localparam logic [WEIGHT_W-1:0] GYRO_WEIGHT_RST    = 17'd60948;
   localparam logic [WEIGHT_W-1:0] ACCEL_WEIGHT_RST   = 17'd4587;
   localparam logic [GAIN_W-1:0]   GYRO_STEP_GAIN_RST = 16'd20;

   typedef struct packed {
      logic [WEIGHT_W-1:0] gyro_weight;
      logic [WEIGHT_W-1:0] accel_weight;
      logic [GAIN_W-1:0]   gyro_step_gain;
   } ctf_cfg_type;

   // Operation issued to both datapath lanes each cycle
   typedef enum logic [2:0] {
      LANE_HOLD,
      LANE_LOAD_GAIN,
      LANE_STEP,
      LANE_LOAD_GYRO,
      LANE_LOAD_ACCEL,
      LANE_FINISH
   } lane_op_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_GAIN,
      ST_CLAMP,
      ST_GYRO,
      ST_SWAP,
      ST_ACCEL,
      ST_FINISH,
      ST_DONE
   } ctf_state_type;

   // How the current transaction produces its result
   typedef enum logic [1:0] {
      MODE_DROP,
      MODE_FIRST,
      MODE_FUSE
   } ctf_mode_type;

endpackage

`default_nettype wire

// File: sv/ctf_lane.sv
// One axis of the filter: digit-serial multiply-accumulate with clamping.
`default_nettype none

module ctf_lane #(
   parameter int ANGLE_W = ctf_pkg::ROLL_W,
   parameter int LIMIT   = ctf_pkg::ROLL_LIMIT
) (
   input  wire logic                              clock,
   input  wire ctf_pkg::lane_op_type              op,
   input  wire ctf_pkg::ctf_cfg_type              cfg,
   input  wire logic signed [ANGLE_W-1:0]         prev_angle,
   input  wire logic signed [ctf_pkg::GYRO_W-1:0] gyro_raw,
   input  wire logic signed [ANGLE_W-1:0]         accel_angle,
   output logic signed [ANGLE_W-1:0]              fused_angle
);
   import ctf_pkg::*;

   // Wide enough for weight * angle sums plus headroom
   localparam int ACC_W = ANGLE_W + WEIGHT_W + 2;
   localparam logic signed [ACC_W-1:0] LIM_HI = ACC_W'(LIMIT);
   localparam logic signed [ACC_W-1:0] LIM_LO = -LIM_HI;

   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [ACC_W-1:0]   mcand_ff, mcand_in;
   logic [WEIGHT_W-1:0]       mplier_ff, mplier_in;
   logic signed [ANGLE_W-1:0] fused_ff, fused_in;

   logic [DIGIT_W-1:0]        digit;
   logic signed [ACC_W-1:0]   partial;
   logic signed [ACC_W-1:0]   clamp_src;
   logic signed [ANGLE_W-1:0] clamped;

   // Partial product of the current multiplier digit
   assign digit   = mplier_ff[DIGIT_W-1:0];
   assign partial = mcand_ff * $signed({1'b0, digit});

   // One shared clamp: raw sum for the gyro angle, scaled sum at the end
   always_comb begin
      clamp_src = (op == LANE_FINISH) ? (acc_ff >>> FRAC_W) : acc_ff;
      if (clamp_src > LIM_HI) begin
         clamped = LIM_HI[ANGLE_W-1:0];
      end else if (clamp_src < LIM_LO) begin
         clamped = LIM_LO[ANGLE_W-1:0];
      end else begin
         clamped = clamp_src[ANGLE_W-1:0];
      end
   end

   // Datapath next values
   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      fused_in  = fused_ff;
      case (op)
         LANE_LOAD_GAIN: begin
            // prev + gyro * gain
            acc_in    = ACC_W'(prev_angle);
            mcand_in  = ACC_W'(gyro_raw);
            mplier_in = WEIGHT_W'(cfg.gyro_step_gain);
         end
         LANE_STEP: begin
            acc_in    = acc_ff + partial;
            mcand_in  = mcand_ff <<< DIGIT_W;
            mplier_in = mplier_ff >> DIGIT_W;
         end
         LANE_LOAD_GYRO: begin
            acc_in    = '0;
            mcand_in  = ACC_W'(clamped);
            mplier_in = cfg.gyro_weight;
         end
         LANE_LOAD_ACCEL: begin
            // drop the fraction so the gyro term is floored on its own
            acc_in    = {acc_ff[ACC_W-1:FRAC_W], FRAC_W'(0)};
            mcand_in  = ACC_W'(accel_angle);
            mplier_in = cfg.accel_weight;
         end
         LANE_FINISH: begin
            fused_in = clamped;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      fused_ff  <= fused_in;
   end

   assign fused_angle = fused_ff;

endmodule

`default_nettype wire

// File: sv/complementary_tilt_filter.sv
// Top level of the per-sensor complementary tilt filter.
//
// Usage: each req transaction carries a sensor index, accelerometer roll and
// pitch angles (signed 9.16 and 8.16 degrees) and raw gyro X/Y counts. Each one gives
// exactly one rsp transaction with the fused roll and pitch. A transaction is
// taken at a rising edge with valid high and stall low on that channel.
// The first transaction for a sensor stores and returns the accelerometer
// angles; an index past the sensor count returns zeros and keeps all state.
// Those results pass from the done state into the result register, and the
// next request is taken once the block is back in idle.
// A fused transaction runs both axes in parallel through an 8-bit-digit
// multiply-accumulate, stepping through the load, gain, clamp, gyro, swap,
// accel, finish and done (write-back) states; the next request is taken
// once the block is back in idle.
// req_stall is high while a transaction is in work. The result register lets
// the block take the next request while rsp is stalled; a finished result
// waits in its last stage until the result register is free.
// Reset clears the seen flags, the output valid and restores the register
// defaults. Registers sit on the csr APB port at 0x0, 0x4 and 0x8.
`default_nettype none

module complementary_tilt_filter #(
   parameter int SENSOR_COUNT = ctf_pkg::SENSOR_COUNT_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request channel
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [ctf_pkg::INDEX_W-1:0]           req_sensor_index,
   input  wire logic signed [ctf_pkg::ROLL_W-1:0]     req_accel_roll_angle,
   input  wire logic signed [ctf_pkg::PITCH_W-1:0]    req_accel_pitch_angle,
   input  wire logic signed [ctf_pkg::GYRO_W-1:0]     req_gyro_x_raw,
   input  wire logic signed [ctf_pkg::GYRO_W-1:0]     req_gyro_y_raw,
   // response channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [ctf_pkg::ROLL_W-1:0]          rsp_fused_roll,
   output logic signed [ctf_pkg::PITCH_W-1:0]         rsp_fused_pitch,
   // configuration port
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [ctf_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  wire logic [ctf_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [ctf_pkg::CSR_DATA_W-1:0]             csr_prdata,
   output logic                                       csr_pready
);
   import ctf_pkg::*;

   localparam int IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

   ctf_state_type state_ff, state_in;
   ctf_mode_type  mode_ff, mode_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   ctf_cfg_type   cfg_ff, cfg_in;
   logic [SENSOR_COUNT-1:0] seen_ff, seen_in;

   logic [IDX_W-1:0]           idx_ff;
   logic signed [ROLL_W-1:0]   meas_roll_ff;
   logic signed [PITCH_W-1:0]  meas_pitch_ff;
   logic signed [GYRO_W-1:0]   gyro_x_ff;
   logic signed [GYRO_W-1:0]   gyro_y_ff;

   logic signed [ROLL_W-1:0]   roll_mem_ff [SENSOR_COUNT];
   logic signed [PITCH_W-1:0]  pitch_mem_ff [SENSOR_COUNT];

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [ROLL_W-1:0]   rsp_roll_ff, rsp_roll_in;
   logic signed [PITCH_W-1:0]  rsp_pitch_ff, rsp_pitch_in;

   logic                       req_accept;
   logic                       idx_ok;
   logic [IDX_W-1:0]           req_idx;
   logic                       out_free;
   logic                       done_fire;
   logic                       cnt_last;
   lane_op_type                lane_op;
   logic signed [ROLL_W-1:0]   lane_roll;
   logic signed [PITCH_W-1:0]  lane_pitch;
   logic signed [ROLL_W-1:0]   res_roll;
   logic signed [PITCH_W-1:0]  res_pitch;
   logic                       csr_write;
   logic [REG_SEL_W-1:0]       reg_sel;

   // Handshake and decode
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign idx_ok     = (32'(req_sensor_index) < SENSOR_COUNT);
   assign req_idx    = req_sensor_index[IDX_W-1:0];
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign done_fire  = (state_ff == ST_DONE) && out_free;

   // Digit counter end condition per phase
   always_comb begin
      case (state_ff)
         ST_GAIN: cnt_last = (cnt_ff == CNT_W'(GAIN_DIGITS - 1));
         default: cnt_last = (cnt_ff == CNT_W'(WEIGHT_DIGITS - 1));
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (idx_ok && seen_ff[req_idx]) begin
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_LOAD:   state_in = ST_GAIN;
         ST_GAIN:   state_in = cnt_last ? ST_CLAMP : ST_GAIN;
         ST_CLAMP:  state_in = ST_GYRO;
         ST_GYRO:   state_in = cnt_last ? ST_SWAP : ST_GYRO;
         ST_SWAP:   state_in = ST_ACCEL;
         ST_ACCEL:  state_in = cnt_last ? ST_FINISH : ST_ACCEL;
         ST_FINISH: state_in = ST_DONE;
         ST_DONE:   state_in = out_free ? ST_IDLE : ST_DONE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: lane operation
   always_comb begin
      case (state_ff)
         ST_LOAD:   lane_op = LANE_LOAD_GAIN;
         ST_GAIN:   lane_op = LANE_STEP;
         ST_CLAMP:  lane_op = LANE_LOAD_GYRO;
         ST_GYRO:   lane_op = LANE_STEP;
         ST_SWAP:   lane_op = LANE_LOAD_ACCEL;
         ST_ACCEL:  lane_op = LANE_STEP;
         ST_FINISH: lane_op = LANE_FINISH;
         default:   lane_op = LANE_HOLD;
      endcase
   end

   // Digit counter: runs in the multiply phases only
   always_comb begin
      case (state_ff)
         ST_GAIN, ST_GYRO, ST_ACCEL: cnt_in = cnt_last ? '0 : cnt_ff + 1'b1;
         default:                    cnt_in = '0;
      endcase
   end

   // Result mode, chosen at acceptance
   always_comb begin
      mode_in = mode_ff;
      if (req_accept) begin
         if (!idx_ok) begin
            mode_in = MODE_DROP;
         end else if (!seen_ff[req_idx]) begin
            mode_in = MODE_FIRST;
         end else begin
            mode_in = MODE_FUSE;
         end
      end
   end

   // Result selection
   always_comb begin
      case (mode_ff)
         MODE_FIRST: begin
            res_roll  = meas_roll_ff;
            res_pitch = meas_pitch_ff;
         end
         MODE_FUSE: begin
            res_roll  = lane_roll;
            res_pitch = lane_pitch;
         end
         default: begin
            res_roll  = '0;
            res_pitch = '0;
         end
      endcase
   end

   // Seen flags update on write-back
   always_comb begin
      seen_in = seen_ff;
      if (done_fire && (mode_ff != MODE_DROP)) begin
         seen_in[idx_ff] = 1'b1;
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_roll_in  = rsp_roll_ff;
      rsp_pitch_in = rsp_pitch_ff;
      if (done_fire) begin
         rsp_valid_in = 1'b1;
         rsp_roll_in  = res_roll;
         rsp_pitch_in = res_pitch;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Register file writes
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_sel)
            REG_GYRO_WEIGHT:    cfg_in.gyro_weight    = csr_pwdata[WEIGHT_W-1:0];
            REG_ACCEL_WEIGHT:   cfg_in.accel_weight   = csr_pwdata[WEIGHT_W-1:0];
            REG_GYRO_STEP_GAIN: cfg_in.gyro_step_gain = csr_pwdata[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Register file reads
   always_comb begin
      case (reg_sel)
         REG_GYRO_WEIGHT:    csr_prdata = CSR_DATA_W'(cfg_ff.gyro_weight);
         REG_ACCEL_WEIGHT:   csr_prdata = CSR_DATA_W'(cfg_ff.accel_weight);
         REG_GYRO_STEP_GAIN: csr_prdata = CSR_DATA_W'(cfg_ff.gyro_step_gain);
         default:            csr_prdata = '0;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_DROP;
         cnt_ff       <= '0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= '{gyro_weight:    GYRO_WEIGHT_RST,
                           accel_weight:   ACCEL_WEIGHT_RST,
                           gyro_step_gain: GYRO_STEP_GAIN_RST};
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         cnt_ff       <= cnt_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         idx_ff         <= req_idx;
         meas_roll_ff   <= req_accel_roll_angle;
         meas_pitch_ff  <= req_accel_pitch_angle;
         gyro_x_ff      <= req_gyro_x_raw;
         gyro_y_ff      <= req_gyro_y_raw;
      end
      if (done_fire && (mode_ff != MODE_DROP)) begin
         roll_mem_ff[idx_ff]  <= res_roll;
         pitch_mem_ff[idx_ff] <= res_pitch;
      end
      rsp_roll_ff  <= rsp_roll_in;
      rsp_pitch_ff <= rsp_pitch_in;
   end

   // Axis datapaths
   ctf_lane #(
      .ANGLE_W (ROLL_W),
      .LIMIT   (ROLL_LIMIT)
   ) u_roll_lane (
      .clock       (clock),
      .op          (lane_op),
      .cfg         (cfg_ff),
      .prev_angle  (roll_mem_ff[idx_ff]),
      .gyro_raw    (gyro_x_ff),
      .accel_angle (meas_roll_ff),
      .fused_angle (lane_roll)
   );

   ctf_lane #(
      .ANGLE_W (PITCH_W),
      .LIMIT   (PITCH_LIMIT)
   ) u_pitch_lane (
      .clock       (clock),
      .op          (lane_op),
      .cfg         (cfg_ff),
      .prev_angle  (pitch_mem_ff[idx_ff]),
      .gyro_raw    (gyro_y_ff),
      .accel_angle (meas_pitch_ff),
      .fused_angle (lane_pitch)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_fused_roll  = rsp_roll_ff;
   assign rsp_fused_pitch = rsp_pitch_ff;

   // An out-of-range sensor yields an all-zero result
   assert property (@(posedge clock) disable iff (reset)
      done_fire && (mode_ff == MODE_DROP) |=>
         (rsp_fused_roll == '0) && (rsp_fused_pitch == '0))
      else $error("dropped transaction returned nonzero angles");

   // A fused result always lies within the angle limits
   assert property (@(posedge clock) disable iff (reset)
      done_fire && (mode_ff == MODE_FUSE) |=>
         (rsp_fused_roll <= ROLL_LIMIT) && (rsp_fused_roll >= -ROLL_LIMIT) &&
         (rsp_fused_pitch <= PITCH_LIMIT) && (rsp_fused_pitch >= -PITCH_LIMIT))
      else $error("fused angle outside its limit");

   // Sensor bookkeeping only changes at write-back
   assert property (@(posedge clock) disable iff (reset)
      !done_fire |=> $stable(seen_ff))
      else $error("seen flags changed outside write-back");

endmodule

`default_nettype wire
